// ----- design/mrle_pkg.sv -----
package mrle_pkg;

    // element size codes held in the configuration register
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_RSVD = 2'd3;

    localparam int ELEM_W      = 32;
    localparam int NUM_SLOTS   = 5;
    localparam int SLOT_W      = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ELEM_W-1:0] RUN_START = 32'd3;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO,
        PH_RUN
    } phase_t;

    // everything one request produces, in output order
    typedef struct packed {
        logic [SLOT_W-1:0]           n;
        elem_t [NUM_SLOTS-1:0]       vals;
    } cmd_t;

    function automatic elem_t elem_mask(input logic [1:0] size);
        elem_t m;
        unique case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_HALF: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic elem_t elem_marker(input logic [1:0] size);
        elem_t m;
        unique case (size)
            SIZE_BYTE: m = 32'h0000_00B4;
            SIZE_HALF: m = 32'h0000_B4B4;
            default:   m = 32'hB4B4_B4B4;
        endcase
        return m;
    endfunction

    function automatic elem_t elem_cap(input logic [1:0] size);
        elem_t m;
        unique case (size)
            SIZE_BYTE: m = 32'd254;
            SIZE_HALF: m = 32'd65535;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ----- design/mrle_front.sv -----
module mrle_front
    import mrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  elem_t       in_value,
    input  logic        in_last,
    output logic        push,
    output cmd_t        push_cmd
);

    logic [1:0] size_reg;
    logic [1:0] size_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    elem_t      held_reg;
    elem_t      held_next;
    elem_t      count_reg;
    elem_t      count_next;

    elem_t      mask;
    elem_t      marker;
    elem_t      v;
    logic       eq;
    logic       pre;
    phase_t     ph_mid;
    cmd_t       cmd;
    logic       accept;

    function automatic cmd_t append(input cmd_t c, input elem_t x);
        cmd_t r;
        r = c;
        r.vals[c.n] = x;
        r.n = c.n + SLOT_W'(1);
        return r;
    endfunction

    assign size_next = (cfg_wdata == SIZE_RSVD) ? SIZE_WORD : cfg_wdata;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        mask   = elem_mask(size_reg);
        marker = elem_marker(size_reg);
        v      = in_value & mask;
        eq     = (v == held_reg);
        pre    = (((phase_reg == PH_ONE) || (phase_reg == PH_TWO)) && !eq)
              || ((phase_reg == PH_RUN) && (!eq || (count_reg >= elem_cap(size_reg))));

        cmd        = '0;
        held_next  = held_reg;
        count_next = count_reg;

        // close what is pending when the new element breaks it or the run count has reached its cap
        if (pre)
        begin
            unique case (phase_reg)
                PH_ONE:
                begin
                    cmd = append(cmd, held_reg);
                end
                PH_TWO:
                begin
                    cmd = append(cmd, held_reg);
                    cmd = append(cmd, held_reg);
                end
                PH_RUN:
                begin
                    cmd = append(cmd, marker);
                    cmd = append(cmd, held_reg);
                    cmd = append(cmd, count_reg);
                end
                default:
                begin
                end
            endcase
        end

        ph_mid     = pre ? PH_IDLE : phase_reg;
        phase_next = ph_mid;

        unique case (ph_mid)
            PH_IDLE:
            begin
                if (v == marker)
                begin
                    cmd = append(cmd, v);
                    cmd = append(cmd, v);
                end
                else
                begin
                    held_next  = v;
                    phase_next = PH_ONE;
                end
            end
            PH_ONE:
            begin
                phase_next = PH_TWO;
            end
            PH_TWO:
            begin
                phase_next = PH_RUN;
                count_next = RUN_START;
            end
            default:
            begin
                count_next = count_reg + ELEM_W'(1);
            end
        endcase

        // end of stream: drain the updated state
        if (in_last)
        begin
            unique case (phase_next)
                PH_ONE:
                begin
                    cmd = append(cmd, held_next);
                end
                PH_TWO:
                begin
                    cmd = append(cmd, held_next);
                    cmd = append(cmd, held_next);
                end
                PH_RUN:
                begin
                    cmd = append(cmd, marker);
                    cmd = append(cmd, held_next);
                    cmd = append(cmd, count_next);
                end
                default:
                begin
                end
            endcase
            phase_next = PH_IDLE;
            held_next  = '0;
            count_next = '0;
        end

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cmd.vals[i] = cmd.vals[i] & mask;
        end
    end

    assign push     = accept && (cmd.n != '0);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_BYTE;
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= size_next;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ----- design/mrle_queue.sv -----
module mrle_queue
    import mrle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/mrle_back.sv -----
module mrle_back
    import mrle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  cmd_t  head_cmd,
    output logic  pop,
    output logic  out_valid,
    input  logic  out_stall,
    output elem_t out_value,
    output logic  out_last
);

    logic [SLOT_W-1:0] sel_reg;
    logic [SLOT_W-1:0] sel_next;
    logic              valid_reg;
    elem_t             value_reg;
    logic              last_reg;
    logic              load;
    logic              final_slot;

    assign load       = head_valid && (!valid_reg || !out_stall);
    assign sel_next   = sel_reg + SLOT_W'(1);
    assign final_slot = (sel_next == head_cmd.n);
    assign pop        = load && final_slot;

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                sel_reg   <= final_slot ? '0 : sel_next;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= head_cmd.vals[sel_reg];
            last_reg  <= final_slot;
        end
    end

endmodule

// ----- design/marker_rle_encoder.sv -----
// a taken request is written into the queue, and its first result then into the output register
// throughput: one request per cycle while each yields at most one result and the output is not stalled
// a request yielding k results (up to five) sends them out in order; the queue absorbs bursts
// the output register drains one result per cycle while out_stall is low and sets the pace under bursts
// reset (rst_n low, asynchronous): queue and output empty, nothing pending, byte elements
module marker_rle_encoder
    import mrle_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: element size
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // raw element requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] in_value,
    input  logic        in_last,
    // encoded element requests
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_value,
    output logic        out_last
);

    // front to queue: one entry per request that yields any result
    logic push;
    cmd_t push_cmd;
    // queue to back
    logic q_full;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // front stalls only when the queue has no room
    assign in_stall = q_full;

    // front: classifies each element against held value and run count,
    // builds the ordered list of results for that request
    mrle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_value  (in_value),
        .in_last   (in_last),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // short queue decouples front from output stalls
    mrle_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back: walks the result list, one element per output cycle while out_stall is low,
    // flags the final one of each request
    mrle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .out_last   (out_last)
    );

endmodule

// ----- design/mrle_checker.sv -----
module mrle_checker
    import mrle_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [1:0]  cfg_wdata,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] in_value,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_value,
    input logic        out_last
);

    logic [1:0] size_reg;
    logic       seen_in_reg;

    // shadow of the element size as seen on the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= SIZE_BYTE;
            seen_in_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= (cfg_wdata == SIZE_RSVD) ? SIZE_WORD : cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                seen_in_reg <= 1'b1;
            end
        end
    end

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_last))
        else $error("output changed under stall");

    // encoded elements never carry bits above the element width
    a_out_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_value & ~elem_mask(size_reg)) == '0))
        else $error("output wider than element size");

    // nothing comes out before any element went in
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_in_reg |-> !out_valid)
        else $error("output without input");

    // leaving reset the block is empty and ready
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("not empty after reset");

endmodule

bind marker_rle_encoder mrle_checker u_mrle_checker (.*);
